// ----- hw/rtl/ssw_pkg.sv -----
// Shared widths and result codes for the subarray-sum sliding-window unit.
// No dependencies; imported by the interfaces and the top level.
`timescale 1ns / 1ps

package ssw_pkg;

    localparam int TARGET_W = 26;
    localparam int STATUS_W = 2;
    localparam int START_W  = 10;
    localparam int LEN_W    = 11;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_FOUND     = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_OVERFLOW  = 2'd2;

endpackage

// ----- hw/rtl/ssw_if.sv -----
// Valid/ready channel interfaces for the subarray-sum sliding-window unit:
// element input, result output and target configuration write.
// Depends on ssw_pkg.
`timescale 1ns / 1ps

interface ssw_in_if #(
    parameter int ELEMENT_BITS = 16
) ();
    logic                    valid;
    logic                    ready;
    logic [ELEMENT_BITS-1:0] element_value;
    logic                    last_element;

    modport source (output valid, output element_value, output last_element, input ready);
    modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

interface ssw_out_if import ssw_pkg::*; ();
    logic               valid;
    logic               ready;
    t_status            status;
    logic [START_W-1:0] start_index;
    logic [LEN_W-1:0]   match_length;

    modport source (output valid, output status, output start_index, output match_length,
                    input ready);
    modport sink   (input valid, input status, input start_index, input match_length,
                    output ready);
endinterface

interface ssw_cfg_if import ssw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TARGET_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/subarray_sum_sliding_window_unit.sv -----
// Top level of the subarray-sum sliding-window unit: sequencer, element store,
// shared add/subtract unit and output register.
// Depends on ssw_pkg and the channel interfaces in ssw_if.sv.
`timescale 1ns / 1ps

// Elements of one array arrive one per input transaction, with a last flag on
// the final one. The unit stores each element, adds it to a running window
// sum and then drops elements from the window's left end while the sum is
// above the target. The first window that equals the target yields one
// result (status found, start index, length); later elements are ignored up
// to the last one. An array that ends without a match yields not found, and
// an element beyond MAX_ELEMENTS yields overflow. A stored element passes
// through accept, add, drain test and match test, with a subtract and a
// further drain test for every element dropped from the window, and an emit
// step when it produces a result; an element beyond the store goes from
// accept to emit, and an ignored element is only accepted. The emit step
// stretches for as long as the output register still holds an earlier result
// that has not been taken. These steps follow from the single adder/subtractor,
// shared between adding and dropping, and from the one registered read port of
// the element store, which delivers one dropped element per read. Input ready
// is high only while the sequencer is idle. A result waits in the output
// register while the next element is being taken in. The target register is
// written through its own channel, which is always ready, and resets to 1.

module subarray_sum_sliding_window_unit import ssw_pkg::*; #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int ELEMENT_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ssw_in_if.sink          i_in,
    ssw_cfg_if.sink         i_cfg,
    ssw_out_if.source       o_out
);

    localparam int AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW    = $clog2(MAX_ELEMENTS + 1);
    localparam int SUM_W = ((ELEMENT_BITS > TARGET_W) ? ELEMENT_BITS : TARGET_W) + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ADD   = 6'b000010,
        S_DRAIN = 6'b000100,
        S_SUB   = 6'b001000,
        S_CHECK = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic [SUM_W-1:0]        r_sum, n_sum;
    logic [CW-1:0]           r_left, n_left;
    logic [CW-1:0]           r_right, n_right;
    logic                    r_done, n_done;
    logic [TARGET_W-1:0]     r_target;
    logic [ELEMENT_BITS-1:0] r_value;
    logic                    r_last;
    logic [ELEMENT_BITS-1:0] r_rd_data;
    t_status                 r_res_status, n_res_status;
    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [START_W-1:0]      r_out_start;
    logic [LEN_W-1:0]        r_out_len;

    logic [ELEMENT_BITS-1:0] r_mem [MAX_ELEMENTS];

    logic                    in_fire;
    logic                    wr_en;
    logic                    rd_en;
    logic                    out_load;
    logic                    over_target;
    logic                    win_nonempty;
    logic [SUM_W-1:0]        target_ext;
    logic [SUM_W-1:0]        alu_b;
    logic [SUM_W-1:0]        alu_y;
    logic [CW-1:0]           win_len;
    logic [CW+START_W-1:0]   start_wide;
    logic [CW+LEN_W-1:0]     len_wide;

    assign in_fire      = i_in.valid && i_in.ready;
    assign i_in.ready   = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    assign target_ext   = {{(SUM_W-TARGET_W){1'b0}}, r_target};
    assign win_nonempty = (r_left < r_right);
    assign over_target  = (r_sum > target_ext) && win_nonempty;
    assign win_len      = r_right - r_left;
    assign start_wide   = {{START_W{1'b0}}, r_left};
    assign len_wide     = {{LEN_W{1'b0}}, win_len};

    // shared adder/subtractor: add the new element, subtract a dropped one
    assign alu_b = (r_state == S_SUB) ? {{(SUM_W-ELEMENT_BITS){1'b0}}, r_rd_data}
                                      : {{(SUM_W-ELEMENT_BITS){1'b0}}, r_value};
    assign alu_y = (r_state == S_SUB) ? (r_sum - alu_b) : (r_sum + alu_b);

    assign wr_en    = in_fire && !r_done && (r_right < CW'(MAX_ELEMENTS));
    assign rd_en    = (r_state == S_DRAIN) && over_target;
    assign out_load = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state      = r_state;
        n_sum        = r_sum;
        n_left       = r_left;
        n_right      = r_right;
        n_done       = r_done;
        n_res_status = r_res_status;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (r_done) begin
                        if (i_in.last_element) begin
                            n_sum   = '0;
                            n_left  = '0;
                            n_right = '0;
                            n_done  = 1'b0;
                        end
                    end else if (r_right >= CW'(MAX_ELEMENTS)) begin
                        n_res_status = ST_OVERFLOW;
                        n_state      = S_EMIT;
                    end else begin
                        n_state = S_ADD;
                    end
                end
            end
            S_ADD: begin
                n_sum   = alu_y;
                n_right = r_right + CW'(1);
                n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = over_target ? S_SUB : S_CHECK;
            end
            S_SUB: begin
                n_sum   = alu_y;
                n_left  = r_left + CW'(1);
                n_state = S_DRAIN;
            end
            S_CHECK: begin
                if ((r_sum == target_ext) && win_nonempty) begin
                    n_res_status = ST_FOUND;
                    n_state      = S_EMIT;
                end else if (r_last) begin
                    n_res_status = ST_NOT_FOUND;
                    n_state      = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                    if (r_last) begin
                        n_sum   = '0;
                        n_left  = '0;
                        n_right = '0;
                        n_done  = 1'b0;
                    end else begin
                        n_done = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sum    <= '0;
            r_left   <= '0;
            r_right  <= '0;
            r_done   <= 1'b0;
            r_target <= TARGET_W'(1);
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_left  <= n_left;
            r_right <= n_right;
            r_done  <= n_done;
            if (i_cfg.valid && i_cfg.ready) begin
                r_target <= i_cfg.data;
            end
        end
    end

    // hold the element under work and the pending result code
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_value <= i_in.element_value;
            r_last  <= i_in.last_element;
        end
        r_res_status <= n_res_status;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_right[AW-1:0]] <= i_in.element_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_left[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_res_status;
            if (r_res_status == ST_FOUND) begin
                r_out_start <= start_wide[START_W-1:0];
                r_out_len   <= len_wide[LEN_W-1:0];
            end else begin
                r_out_start <= '0;
                r_out_len   <= '0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.start_index  = r_out_start;
    assign o_out.match_length = r_out_len;

    a_left_le_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= r_right)
        else $error("window left index passed right index");

    a_right_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_right <= CW'(MAX_ELEMENTS))
        else $error("element count beyond store depth");

    a_drained_at_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> !over_target)
        else $error("window sum above target after draining");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_done && i_in.last_element) |=> (r_right == '0) && !r_done)
        else $error("array state not cleared by last element after a result");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> r_out_valid && $stable(r_out_status))
        else $error("pending result overwritten");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for subarray_sum_sliding_window_unit: directed and
// random arrays on the element channel, target writes, checked results.
// Depends on ssw_pkg, the channel interfaces in ssw_if.sv and the top level.
`timescale 1ns / 1ps

module tb import ssw_pkg::*; ();

    localparam int MAX_ELEMS    = 1024;
    localparam int ELEM_W       = 16;
    localparam int ELEM_MAX     = 65535;
    localparam int BUSY_CYCLES  = 4 + 2 * MAX_ELEMS + 16;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 450;
    localparam int END_WAIT     = 20000;
    localparam int MAX_PRINTS   = 100;
    localparam logic [TARGET_W-1:0] TARGET_TOP = {TARGET_W{1'b1}};

    typedef struct packed {
        t_status            status;
        logic [START_W-1:0] start_index;
        logic [LEN_W-1:0]   match_length;
    } sum_result_t;

    // Window-sum predictor and queue of results still owed by the block.
    class window_sum_scoreboard;
        localparam int DEPTH = 1024;

        logic [ELEM_W-1:0]   elem_store [DEPTH];
        logic [26:0]         run_sum;
        logic [10:0]         left_pos;
        logic [10:0]         right_pos;
        bit                  matched;
        logic [TARGET_W-1:0] target;
        sum_result_t         owed_q [$];

        function new();
            target = 1;
            clear_array();
        endfunction

        function void clear_array();
            run_sum   = '0;
            left_pos  = '0;
            right_pos = '0;
            matched   = 1'b0;
        endfunction

        function void set_target(logic [TARGET_W-1:0] value);
            target = value;
        endfunction

        function void owe(t_status status, logic [START_W-1:0] start,
                          logic [LEN_W-1:0] length);
            sum_result_t res;
            res.status       = status;
            res.start_index  = start;
            res.match_length = length;
            owed_q.push_back(res);
        endfunction

        // Returns 0 when the block simply drops the element.
        function bit note_element(logic [ELEM_W-1:0] value, logic last);
            if (matched) begin
                if (last) clear_array();
                return 1'b0;
            end
            if (right_pos >= DEPTH) begin
                owe(ST_OVERFLOW, '0, '0);
                if (last) clear_array();
                else matched = 1'b1;
                return 1'b1;
            end
            elem_store[right_pos[9:0]] = value;
            right_pos = right_pos + 1'b1;
            run_sum   = run_sum + value;
            while (run_sum > {1'b0, target} && left_pos < right_pos) begin
                run_sum  = run_sum - elem_store[left_pos[9:0]];
                left_pos = left_pos + 1'b1;
            end
            if (run_sum == {1'b0, target} && left_pos < right_pos) begin
                owe(ST_FOUND, left_pos[9:0], right_pos - left_pos);
                if (last) clear_array();
                else matched = 1'b1;
                return 1'b1;
            end
            if (last) begin
                owe(ST_NOT_FOUND, '0, '0);
                clear_array();
            end
            return 1'b1;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Empty string when the result matches the oldest one owed.
        function string check_result(sum_result_t got);
            sum_result_t want;
            string       msg;
            if (owed_q.size() == 0)
                return $sformatf("unexpected result: status %0d start %0d length %0d",
                                 got.status, got.start_index, got.match_length);
            want = owed_q.pop_front();
            msg  = "";
            if (got.status != want.status)
                msg = {msg, $sformatf(" status %0d/%0d", got.status, want.status)};
            if (got.start_index != want.start_index)
                msg = {msg, $sformatf(" start %0d/%0d", got.start_index, want.start_index)};
            if (got.match_length != want.match_length)
                msg = {msg, $sformatf(" length %0d/%0d", got.match_length,
                                      want.match_length)};
            if (msg != "") msg = {"result fields got/want:", msg};
            return msg;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ssw_in_if #(.ELEMENT_BITS(ELEM_W)) in_ch ();
    ssw_out_if                         out_ch ();
    ssw_cfg_if                         cfg_ch ();

    subarray_sum_sliding_window_unit #(
        .MAX_ELEMENTS (MAX_ELEMS),
        .ELEMENT_BITS (ELEM_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    window_sum_scoreboard sums = new();

    int                mismatch_count = 0;
    bit                steady_mode    = 1'b0;
    bit                long_hold_req  = 1'b0;
    logic [ELEM_W-1:0] array_q [$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("TIMEOUT at %0t", $time);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Result receiver: random stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        int r;
        out_ch.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (steady_mode) begin
                out_ch.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    out_ch.ready <= 1'b1;
                end else if (r < 96) begin
                    out_ch.ready <= 1'b0;
                    stall_left   = $urandom_range(0, 2);
                end else begin
                    out_ch.ready <= 1'b0;
                    stall_left   = $urandom_range(15, 60);
                end
            end
        end
    end

    initial begin
        sum_result_t got;
        string       msg;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.status       = out_ch.status;
                got.start_index  = out_ch.start_index;
                got.match_length = out_ch.match_length;
                msg = sums.check_result(got);
                if (msg != "") report_mismatch(msg);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ELEM_W-1:0] pick_element(int unsigned cap);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return $urandom_range(0, ELEM_MAX);
        return $urandom_range(0, cap);
    endfunction

    function automatic logic [TARGET_W-1:0] pick_target();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 1;
        if (r == 1) return TARGET_TOP;
        if (r < 7)  return $urandom_range(1, 16);
        if (r < 12) return $urandom_range(17, 1000);
        if (r < 16) return $urandom_range(1001, ELEM_MAX);
        return $urandom_range(ELEM_MAX + 1, ELEM_MAX * 6);
    endfunction

    // Enter and leave on a falling edge.
    task automatic write_target(input logic [TARGET_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do begin
            @(posedge i_clk);
        end while (cfg_ch.ready !== 1'b1);
        sums.set_target(value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_element(input logic [ELEM_W-1:0] value, input logic last,
                                output bit took);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.element_value <= value;
        in_ch.last_element  <= last;
        do begin
            @(posedge i_clk);
        end while (in_ch.ready !== 1'b1);
        took = sums.note_element(value, last);
        @(negedge i_clk);
    endtask

    // Send array_q as one array, last marker on its final element.
    task automatic send_array(output int took_count);
        bit took;
        took_count = 0;
        for (int i = 0; i < array_q.size(); i++) begin
            send_element(array_q[i], i == array_q.size() - 1, took);
            if (took) took_count++;
        end
        array_q.delete();
    endtask

    task automatic wait_results();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (sums.pending() != 0) @(negedge i_clk);
    endtask

    // The last element may still be in flight with no result owed.
    task automatic settle_block();
        wait_results();
        repeat (BUSY_CYCLES) @(negedge i_clk);
    endtask

    task automatic build_random_array(input logic [TARGET_W-1:0] tgt);
        int unsigned cap;
        int unsigned remaining;
        int unsigned lo;
        int unsigned hi;
        int          parts;
        cap = (tgt > ELEM_MAX) ? ELEM_MAX : tgt;
        if ($urandom_range(0, 9) < 7 && tgt <= ELEM_MAX * 8) begin
            repeat ($urandom_range(0, 6)) array_q.push_back(pick_element(cap));
            // Plant a run that sums exactly to the target.
            remaining = tgt;
            parts     = (tgt + ELEM_MAX - 1) / ELEM_MAX + $urandom_range(0, 2);
            for (int left = parts; left > 1; left--) begin
                lo = (remaining > ELEM_MAX * (left - 1)) ?
                     remaining - ELEM_MAX * (left - 1) : 0;
                hi = (remaining < ELEM_MAX) ? remaining : ELEM_MAX;
                array_q.push_back($urandom_range(lo, hi));
                remaining -= array_q[array_q.size() - 1];
            end
            array_q.push_back(remaining);
            repeat ($urandom_range(0, 6)) array_q.push_back(pick_element(cap));
        end else begin
            repeat ($urandom_range(1, 10)) array_q.push_back(pick_element(cap));
        end
    endtask

    task automatic send_long_array(input int length);
        int took_count;
        repeat (length) array_q.push_back($urandom_range(0, ELEM_MAX));
        send_array(took_count);
    endtask

    initial begin
        int                  took_count;
        int                  random_count;
        int                  waited;
        logic [TARGET_W-1:0] tgt;

        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.element_value = '0;
        in_ch.last_element  = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset target of one first.
        array_q = '{16'd1};                 send_array(took_count);
        array_q = '{16'd0, 16'd0, 16'd1};   send_array(took_count);
        array_q = '{16'hFFFF};              send_array(took_count);
        array_q = '{16'd2, 16'd1};          send_array(took_count);
        settle_block();
        write_target(5);
        // Early match, then ignored elements up to last.
        array_q = '{16'd5, 16'd7, 16'd9, 16'd3}; send_array(took_count);
        array_q = '{16'd3, 16'd1, 16'd1, 16'd4}; send_array(took_count);
        // Match on the last element after a drop.
        array_q = '{16'd7, 16'd5};               send_array(took_count);
        settle_block();
        write_target(3 * ELEM_MAX);
        array_q = '{16'hFFFF, 16'hFFFF, 16'hFFFF}; send_array(took_count);
        settle_block();
        write_target(TARGET_TOP);
        array_q = '{16'hFFFF, 16'hFFFF};           send_array(took_count);

        // Store limits: fill the store, overflow, then an ignored last element.
        send_long_array(MAX_ELEMS + 2);
        array_q = '{16'd9};                        send_array(took_count);

        random_count = 0;
        for (int phase = 0; random_count < RANDOM_ITEMS; phase++) begin
            settle_block();
            tgt = pick_target();
            write_target(tgt);
            steady_mode = (phase > 0) && ($urandom_range(0, 3) == 0);
            // Hold results back while elements keep coming.
            if (phase == 0 || $urandom_range(0, 9) == 0) long_hold_req = 1'b1;
            repeat ($urandom_range(3, 12)) begin
                build_random_array(tgt);
                send_array(took_count);
                random_count += took_count;
                if (phase == 1 || $urandom_range(0, 7) == 0) wait_results();
            end
        end

        steady_mode = 1'b0;
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        waited = 0;
        while (sums.pending() != 0 && waited < END_WAIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (BUSY_CYCLES) @(negedge i_clk);
        if (sums.pending() != 0)
            report_mismatch($sformatf("%0d results never arrived", sums.pending()));
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
